/* src/ddwpc_pkg.sv */
package ddwpc_pkg;

    localparam int NUM_PAIRS_DEF = 4;

    localparam logic [1:0] REQ_CMD   = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [2:0] CFG_LIMIT_ENABLE = 3'd0;
    localparam logic [2:0] CFG_LINEAR_MAX   = 3'd1;
    localparam logic [2:0] CFG_LINEAR_MIN   = 3'd2;
    localparam logic [2:0] CFG_ANGULAR_MAX  = 3'd3;
    localparam logic [2:0] CFG_ANGULAR_MIN  = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT_US   = 3'd5;
    localparam logic [2:0] CFG_TRACK_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_WHEEL_RAD    = 3'd7;

    localparam logic signed [31:0] LIN_NEAR_RAW = 32'sd65;
    localparam logic signed [31:0] ANG_NEAR_RAW = 32'sd131;

    localparam logic signed [31:0] LIMIT_MAX_RST = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LIMIT_MIN_RST = 32'sh8000_0000;
    localparam logic [31:0]        TIMEOUT_RST   = 32'd500000;
    localparam logic [30:0]        LENGTH_RST    = 31'd65536;

    localparam int DIV_STEPS = 64;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [1:0]         pair_index;
        logic signed [31:0] linear_offset;
        logic signed [31:0] angular_offset;
        logic [31:0]        now_time;
        logic signed [31:0] left_measured;
        logic signed [31:0] right_measured;
    } req_t;

    typedef struct packed {
        logic [1:0]         out_pair;
        logic signed [31:0] left_position_cmd;
        logic signed [31:0] right_position_cmd;
        logic               last_pair;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage

/* src/diff_drive_wheel_position_command.sv */
// Command and setpoint reset words are taken in the idle state and leave the block idle.
// A tick word holds the input off until its last pair's word is emitted; the block runs MUL,
// then PREP and DIV for the left offset, PREP and DIV for the right, then EMIT, one pair per
// cycle while the output is not stalled. One shared 1-bit-per-cycle divider serves both offsets.
// Reset (rst_n low, asynchronous) clears held command, setpoints and acceptance and restores config defaults.
module diff_drive_wheel_position_command #(
    parameter int NUM_PAIRS = ddwpc_pkg::NUM_PAIRS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ddwpc_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ddwpc_pkg::rsp_t   rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int PW = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam int SW = $clog2(ddwpc_pkg::DIV_STEPS);

    ddwpc_pkg::state_t state_reg, state_next;

    logic [1:0]         limit_en_reg, limit_en_next;
    logic signed [31:0] lin_max_reg, lin_max_next;
    logic signed [31:0] lin_min_reg, lin_min_next;
    logic signed [31:0] ang_max_reg, ang_max_next;
    logic signed [31:0] ang_min_reg, ang_min_next;
    logic [31:0]        timeout_reg, timeout_next;
    logic [30:0]        track_reg, track_next;
    logic [30:0]        rad_reg, rad_next;

    logic signed [31:0] held_lin_reg, held_lin_next;
    logic signed [31:0] held_ang_reg, held_ang_next;
    logic [31:0]        held_stamp_reg, held_stamp_next;
    logic               accepting_reg, accepting_next;
    logic signed [31:0] left_sp_reg [NUM_PAIRS];
    logic signed [31:0] left_sp_next [NUM_PAIRS];
    logic signed [31:0] right_sp_reg [NUM_PAIRS];
    logic signed [31:0] right_sp_next [NUM_PAIRS];

    logic signed [31:0] lin_reg, lin_next;
    logic signed [31:0] ang_reg, ang_next;
    logic signed [63:0] spin_reg, spin_next;
    logic               side_reg, side_next;
    logic               neg_reg, neg_next;
    logic [63:0]        dq_reg, dq_next;
    logic [32:0]        rem_reg, rem_next;
    logic [SW-1:0]      step_reg, step_next;
    logic signed [63:0] off_l_reg, off_l_next;
    logic signed [63:0] off_r_reg, off_r_next;
    logic [PW-1:0]      cnt_reg, cnt_next;

    logic               rsp_valid_reg, rsp_valid_next;
    ddwpc_pkg::rsp_t    rsp_reg, rsp_next;

    logic               req_take;
    logic               pair_ok;
    logic [PW-1:0]      widx;
    logic               near_zero;
    logic               acc_tick;
    logic [31:0]        age;
    logic signed [31:0] lin_v, ang_v;
    logic signed [63:0] prod;
    logic signed [63:0] lin_sh, num;
    logic [32:0]        div_val;
    logic [33:0]        trial;
    logic               q_bit;
    logic [63:0]        quot;
    logic signed [63:0] off_v;
    logic signed [64:0] sum_l, sum_r;
    logic               last_v;
    logic               out_free;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (!v[64] && (v[63:31] != '0)) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v[64] && (v[63:31] != '1)) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign req_stall = (state_reg != ddwpc_pkg::ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign pair_ok   = ({3'b000, req.pair_index} < 5'(NUM_PAIRS));
    assign widx      = PW'(req.pair_index);
    assign near_zero = (held_lin_reg >= -ddwpc_pkg::LIN_NEAR_RAW)
                    && (held_lin_reg <= ddwpc_pkg::LIN_NEAR_RAW)
                    && (held_ang_reg >= -ddwpc_pkg::ANG_NEAR_RAW)
                    && (held_ang_reg <= ddwpc_pkg::ANG_NEAR_RAW);
    assign acc_tick  = accepting_reg || near_zero;
    assign age       = req.now_time - held_stamp_reg;

    assign prod    = $signed(ang_reg) * $signed({1'b0, track_reg});
    assign lin_sh  = {{15{lin_reg[31]}}, lin_reg, 17'b0};
    assign num     = side_reg ? (lin_sh + spin_reg) : (lin_sh - spin_reg);
    assign div_val = {1'b0, ((rad_reg == '0) ? 31'd1 : rad_reg), 1'b0};
    assign trial   = {rem_reg, dq_reg[63]} - {1'b0, div_val};
    assign q_bit   = !trial[33];
    assign quot    = {dq_reg[62:0], q_bit};
    assign off_v   = neg_reg ? -$signed(quot) : $signed(quot);

    assign sum_l  = 65'(left_sp_reg[cnt_reg]) + 65'(off_l_reg);
    assign sum_r  = 65'(right_sp_reg[cnt_reg]) + 65'(off_r_reg);
    assign last_v = (cnt_reg == PW'(NUM_PAIRS - 1));

    always_comb
    begin
        lin_v = held_lin_reg;
        ang_v = held_ang_reg;
        if ((age > timeout_reg) || !acc_tick)
        begin
            lin_v = '0;
            ang_v = '0;
        end
        if (limit_en_reg[0])
        begin
            if (lin_v < lin_min_reg)
            begin
                lin_v = lin_min_reg;
            end
            else if (lin_v > lin_max_reg)
            begin
                lin_v = lin_max_reg;
            end
        end
        if (limit_en_reg[1])
        begin
            if (ang_v < ang_min_reg)
            begin
                ang_v = ang_min_reg;
            end
            else if (ang_v > ang_max_reg)
            begin
                ang_v = ang_max_reg;
            end
        end
    end

    always_comb
    begin
        limit_en_next   = limit_en_reg;
        lin_max_next    = lin_max_reg;
        lin_min_next    = lin_min_reg;
        ang_max_next    = ang_max_reg;
        ang_min_next    = ang_min_reg;
        timeout_next    = timeout_reg;
        track_next      = track_reg;
        rad_next        = rad_reg;
        held_lin_next   = held_lin_reg;
        held_ang_next   = held_ang_reg;
        held_stamp_next = held_stamp_reg;
        accepting_next  = accepting_reg;
        left_sp_next    = left_sp_reg;
        right_sp_next   = right_sp_reg;
        state_next      = state_reg;
        lin_next        = lin_reg;
        ang_next        = ang_reg;
        spin_next       = spin_reg;
        side_next       = side_reg;
        neg_next        = neg_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        off_l_next      = off_l_reg;
        off_r_next      = off_r_reg;
        cnt_next        = cnt_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ddwpc_pkg::CFG_LIMIT_ENABLE: limit_en_next = cfg_data[1:0];
                ddwpc_pkg::CFG_LINEAR_MAX:   lin_max_next  = cfg_data;
                ddwpc_pkg::CFG_LINEAR_MIN:   lin_min_next  = cfg_data;
                ddwpc_pkg::CFG_ANGULAR_MAX:  ang_max_next  = cfg_data;
                ddwpc_pkg::CFG_ANGULAR_MIN:  ang_min_next  = cfg_data;
                ddwpc_pkg::CFG_TIMEOUT_US:   timeout_next  = cfg_data;
                ddwpc_pkg::CFG_TRACK_WIDTH:  track_next    = cfg_data[30:0];
                ddwpc_pkg::CFG_WHEEL_RAD:    rad_next      = cfg_data[30:0];
                default:                     rad_next      = rad_reg;
            endcase
        end

        unique case (state_reg)
            ddwpc_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    unique case (req.req_type)
                        ddwpc_pkg::REQ_CMD:
                        begin
                            held_lin_next   = req.linear_offset;
                            held_ang_next   = req.angular_offset;
                            held_stamp_next = req.now_time;
                        end
                        ddwpc_pkg::REQ_RESET:
                        begin
                            if (pair_ok)
                            begin
                                left_sp_next[widx]  = req.left_measured;
                                right_sp_next[widx] = req.right_measured;
                                accepting_next      = 1'b0;
                            end
                        end
                        ddwpc_pkg::REQ_TICK:
                        begin
                            accepting_next = acc_tick;
                            lin_next       = lin_v;
                            ang_next       = ang_v;
                            state_next     = ddwpc_pkg::ST_MUL;
                        end
                        default:
                        begin
                            state_next = ddwpc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ddwpc_pkg::ST_MUL:
            begin
                spin_next  = prod;
                side_next  = 1'b0;
                state_next = ddwpc_pkg::ST_PREP;
            end
            ddwpc_pkg::ST_PREP:
            begin
                neg_next   = num[63];
                dq_next    = num[63] ? 64'(-num) : 64'(num);
                rem_next   = '0;
                step_next  = '0;
                state_next = ddwpc_pkg::ST_DIV;
            end
            ddwpc_pkg::ST_DIV:
            begin
                rem_next  = q_bit ? trial[32:0] : {rem_reg[31:0], dq_reg[63]};
                dq_next   = quot;
                step_next = SW'(step_reg + 1'b1);
                if (step_reg == SW'(ddwpc_pkg::DIV_STEPS - 1))
                begin
                    if (!side_reg)
                    begin
                        off_l_next = off_v;
                        side_next  = 1'b1;
                        state_next = ddwpc_pkg::ST_PREP;
                    end
                    else
                    begin
                        off_r_next = off_v;
                        cnt_next   = '0;
                        state_next = ddwpc_pkg::ST_EMIT;
                    end
                end
            end
            ddwpc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_next.out_pair           = 2'(cnt_reg);
                    rsp_next.left_position_cmd  = sat32(sum_l);
                    rsp_next.right_position_cmd = sat32(sum_r);
                    rsp_next.last_pair          = last_v;
                    cnt_next                    = PW'(cnt_reg + 1'b1);
                    if (last_v)
                    begin
                        state_next = ddwpc_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ddwpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ddwpc_pkg::ST_IDLE;
            limit_en_reg   <= '0;
            lin_max_reg    <= ddwpc_pkg::LIMIT_MAX_RST;
            lin_min_reg    <= ddwpc_pkg::LIMIT_MIN_RST;
            ang_max_reg    <= ddwpc_pkg::LIMIT_MAX_RST;
            ang_min_reg    <= ddwpc_pkg::LIMIT_MIN_RST;
            timeout_reg    <= ddwpc_pkg::TIMEOUT_RST;
            track_reg      <= ddwpc_pkg::LENGTH_RST;
            rad_reg        <= ddwpc_pkg::LENGTH_RST;
            held_lin_reg   <= '0;
            held_ang_reg   <= '0;
            held_stamp_reg <= '0;
            accepting_reg  <= 1'b0;
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                left_sp_reg[i]  <= '0;
                right_sp_reg[i] <= '0;
            end
            side_reg       <= 1'b0;
            step_reg       <= '0;
            cnt_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limit_en_reg   <= limit_en_next;
            lin_max_reg    <= lin_max_next;
            lin_min_reg    <= lin_min_next;
            ang_max_reg    <= ang_max_next;
            ang_min_reg    <= ang_min_next;
            timeout_reg    <= timeout_next;
            track_reg      <= track_next;
            rad_reg        <= rad_next;
            held_lin_reg   <= held_lin_next;
            held_ang_reg   <= held_ang_next;
            held_stamp_reg <= held_stamp_next;
            accepting_reg  <= accepting_next;
            left_sp_reg    <= left_sp_next;
            right_sp_reg   <= right_sp_next;
            side_reg       <= side_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg   <= lin_next;
        ang_reg   <= ang_next;
        spin_reg  <= spin_next;
        neg_reg   <= neg_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        off_l_reg <= off_l_next;
        off_r_reg <= off_r_next;
        rsp_reg   <= rsp_next;
    end

endmodule

/* src/ddwpc_checker.sv */
module ddwpc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input ddwpc_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input ddwpc_pkg::rsp_t rsp
);

    logic tick_take;
    logic rsp_take;

    assign tick_take = req_valid && !req_stall && (req.req_type == ddwpc_pkg::REQ_TICK);
    assign rsp_take  = rsp_valid && !rsp_stall;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled output word changed");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick_take |=> req_stall && !rsp_valid || req_stall && $past(rsp_valid && rsp_stall))
        else $error("block took a word right after a tick");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last_pair |-> req_stall)
        else $error("input taken in the middle of a pair run");

    a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take && !rsp.last_pair |=> rsp_valid)
        else $error("gap inside a pair run");

    a_pair_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take && !rsp.last_pair |=> rsp.out_pair == 2'($past(rsp.out_pair) + 2'd1))
        else $error("pair numbers not consecutive");

endmodule

bind diff_drive_wheel_position_command ddwpc_checker u_ddwpc_checker (.*);
